/* src/i2da_pkg.sv */
// Shared constants for the decimal ASCII conversion unit.
// Depends on nothing; used by integer_to_decimal_ascii_unit.
`default_nettype none

package i2da_pkg;

   localparam int VALUE_W    = 64;              // width of the binary value
   localparam int DIGIT_W    = 4;               // one BCD digit
   localparam int NUM_DIGITS = 20;              // decimal digits of 2^64-1
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 6;               // ASCII code width on the bus
   localparam int BITCNT_W   = $clog2(VALUE_W);
   localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  ASCII_MINUS = CHAR_W'(45);
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = DIGIT_W'(3);

   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

`default_nettype wire

/* src/integer_to_decimal_ascii_unit.sv */
// Binary to decimal ASCII conversion, bit-serial double-dabble core.
// Steps: the value is shifted in bit by bit through the double-dabble loop, leading zero
// digits are dropped (up to 19), then the optional minus sign and the digits are emitted.
// A new request is taken only in idle, after the last digit of the previous text has been
// loaded into the output register; output stalls hold back the sign and the digits.
// Reset: synchronous, active high; clears the sequencer and the output valid flag. Needs i2da_pkg.
`default_nettype none

module integer_to_decimal_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic        req_tuser,   // [0] is_signed
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] character, [7:6] zero
   output logic             rsp_tlast    // last character of the text
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam int VW = i2da_pkg::VALUE_W;
   localparam int DW = i2da_pkg::DIGIT_W;
   localparam int ND = i2da_pkg::NUM_DIGITS;
   localparam int BW = i2da_pkg::BCD_W;
   localparam int CW = i2da_pkg::CHAR_W;
   localparam int BCW = i2da_pkg::BITCNT_W;
   localparam int DCW = i2da_pkg::DIGCNT_W;

   logic [2:0]     state_ff, state_in;
   logic [VW-1:0]  bin_ff, bin_in;
   logic [BW-1:0]  bcd_ff, bcd_in;
   logic [BCW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0] dig_cnt_ff, dig_cnt_in;
   logic           neg_ff, neg_in;
   logic           out_valid_ff, out_valid_in;
   logic [CW-1:0]  out_char_ff, out_char_in;
   logic           out_last_ff, out_last_in;

   logic [BW-1:0]        bcd_adj;
   i2da_pkg::digit_type  top_digit;
   logic                 out_free;
   logic                 req_neg;

   // add three to every digit of five or more before the shift
   always_comb begin
      i2da_pkg::digit_type d;
      for (int i = 0; i < ND; i++) begin
         d = bcd_ff[i*DW +: DW];
         bcd_adj[i*DW +: DW] = (d >= i2da_pkg::DABBLE_LIMIT) ?
                               DW'(d + i2da_pkg::DABBLE_ADD) : d;
      end
   end

   assign top_digit  = bcd_ff[BW-1 -: DW];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_neg    = req_tuser && req_tdata[VW-1];

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // two's complement negation also yields 2^63 for the most negative value
               bin_in     = req_neg ? (~req_tdata + VW'(1)) : req_tdata;
               neg_in     = req_neg;
               bcd_in     = '0;
               bit_cnt_in = BCW'(VW - 1);
               dig_cnt_in = DCW'(ND);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BW-2:0], bin_ff[VW-1]};
            bin_in = {bin_ff[VW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BCW'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && dig_cnt_ff != DCW'(1)) begin
               bcd_in     = {bcd_ff[BW-DW-1:0], {DW{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DCW'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = i2da_pkg::ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = i2da_pkg::ASCII_ZERO | CW'(top_digit);
               out_last_in  = (dig_cnt_ff == DCW'(1));
               bcd_in       = {bcd_ff[BW-DW-1:0], {DW{1'b0}}};
               dig_cnt_in   = dig_cnt_ff - DCW'(1);
               if (dig_cnt_ff == DCW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   // digit count untouched while bits are shifted in
   a_conv_count : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> dig_cnt_ff == DCW'(ND))
      else $error("digit count changed during conversion");

   // never run out of digits before the last character
   a_digits_left : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> dig_cnt_ff != '0)
      else $error("digit count reached zero while emitting");

   // an accepted request starts the conversion on the next cycle
   a_start_conv : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CONV && bit_cnt_ff == BCW'(VW - 1))
      else $error("conversion did not start after request");

   // only a sign or a decimal digit leaves the block
   a_char_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_char_ff == i2da_pkg::ASCII_MINUS && !out_last_ff) ||
                     (out_char_ff >= i2da_pkg::ASCII_ZERO &&
                      out_char_ff <= i2da_pkg::ASCII_ZERO + CW'(9)))
      else $error("character out of range");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for integer_to_decimal_ascii_unit: streams 64-bit requests in
// bursts, predicts the decimal text of each and checks every character returned.
// Depends on i2da_pkg and the unit under test.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_COUNT  = 260;
   localparam int IDLE_LIMIT = 4000;   // cycles with no request and no character taken
   localparam int TAIL_WAIT  = 120;    // longest conversion plus a margin
   localparam int MAX_SHOWN  = 10;

   typedef struct {
      logic [i2da_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   class decimal_text_board;
      text_char_type expected_chars[$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Append the text of one accepted request to the expected characters.
      function void note_request(input logic [63:0] value, input logic sgn);
         logic             neg;
         logic [63:0]      mag;
         logic [3:0]       digits[20];
         int               count;
         text_char_type    item;
         neg   = sgn && value[63];
         mag   = neg ? (~value + 64'd1) : value;
         count = 0;
         do begin
            digits[count] = 4'(mag % 64'd10);
            mag           = mag / 64'd10;
            count++;
         end while (mag != 64'd0 && count < 20);
         if (neg) begin
            item.character = i2da_pkg::ASCII_MINUS;
            item.last      = 1'b0;
            expected_chars.push_back(item);
         end
         for (int i = count - 1; i >= 0; i--) begin
            item.character = i2da_pkg::ASCII_ZERO + i2da_pkg::CHAR_W'(digits[i]);
            item.last      = (i == 0);
            expected_chars.push_back(item);
         end
      endfunction

      function void report(input string what);
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("%0t: %s", $realtime, what);
      endfunction

      function void check_char(input logic [7:0] data, input logic last);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected character data=%h last=%b", data, last));
            return;
         end
         want = expected_chars.pop_front();
         if (data !== {2'b00, want.character} || last !== want.last)
            report($sformatf("character mismatch: expected data=%h last=%b, got data=%h last=%b",
                             {2'b00, want.character}, want.last, data, last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] value
   logic        req_tuser = 1'b0; // [0] is_signed
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [5:0] character, [7:6] zero
   logic        rsp_tlast;

   decimal_text_board board = new();

   integer_to_decimal_ascii_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Receiver: runs of ready and stall of random length, now and then a long stall.
   int ready_left = 0;
   always @(negedge clock) begin
      if (ready_left == 0) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               rsp_tready <= 1'b1;
               ready_left <= $urandom_range(1, 30);
            end
            2, 3: begin
               rsp_tready <= 1'($urandom_range(0, 1));
               ready_left <= 1;
            end
            4: begin
               rsp_tready <= 1'b0;
               ready_left <= $urandom_range(1, 6);
            end
            default: begin
               rsp_tready <= 1'b0;
               ready_left <= $urandom_range(10, 40);
            end
         endcase
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_char(rsp_tdata, rsp_tlast);
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Called at a falling edge; leaves valid high for a following request.
   task automatic send_request(input logic [63:0] value, input logic sgn);
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = sgn;
      do @(posedge clock); while (!req_tready);
      board.note_request(value, sgn);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_tvalid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Drop valid and hold until every expected character has come back.
   task automatic drain_text();
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] p;
      int          exp10;
      p = 64'd1;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 1000));
         2: begin
            exp10 = $urandom_range(0, 19);
            repeat (exp10) p = p * 64'd10;
            return p + 64'($urandom_range(0, 2)) - 64'd1;
         end
         3: return {$urandom, $urandom} >> $urandom_range(0, 63);
         4: return -64'($urandom_range(1, 1000));
         default: begin
            case ($urandom_range(0, 3))
               0: return '1;
               1: return 64'h8000_0000_0000_0000;
               2: return 64'h7FFF_FFFF_FFFF_FFFF;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero, single digits, digit-count boundaries, the extremes in both modes.
      send_request(64'd0, 1'b0);
      send_request(64'd0, 1'b1);
      send_request(64'd1, 1'b0);
      send_request(64'd9, 1'b1);
      send_request(64'd10, 1'b0);
      send_request(64'd99, 1'b0);
      send_request(64'd100, 1'b1);
      send_request('1, 1'b0);
      send_request('1, 1'b1);
      send_request(64'h8000_0000_0000_0000, 1'b1);
      send_request(64'h8000_0000_0000_0000, 1'b0);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(64'h8000_0000_0000_0001, 1'b1);
      send_request(64'd10000000000000000000, 1'b0);
      send_request(64'd9999999999999999999, 1'b0);
      send_request(64'd1000000000000000000, 1'b1);
      send_request(-64'd10, 1'b1);
      send_request(-64'd10, 1'b0);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_request(64'h5555_5555_5555_5555, 1'b0);
      drain_text();

      sent = 0;
      while (sent < REQ_COUNT) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < REQ_COUNT; i++) begin
            send_request(random_value(), 1'($urandom_range(0, 1)));
            sent++;
         end
         if (sent >= REQ_COUNT / 2 && sent < REQ_COUNT / 2 + burst)
            drain_text();
         else if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 40));
      end

      drain_text();
      repeat (TAIL_WAIT) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
src/i2da_pkg.sv
src/integer_to_decimal_ascii_unit.sv
tb/tb_top.sv
